[sv/lcs_pkg.sv]
// Shared types, constants and helpers for the link connection supervisor.
// No dependencies; imported by lcs_fsm and link_connection_supervisor.
`default_nettype none

package lcs_pkg;

  // Countdown width in bits, valid from 16 to 32.
  localparam int TIMER_BITS = 24;

  localparam int TICK_W     = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_TIMEOUT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_EN     = 3'd5;

  // Reset values of the configuration registers
  localparam logic [TICK_W-1:0]     RST_TICK_PERIOD     = 16'd10;
  localparam logic [CFG_DATA_W-1:0] RST_CONNECT_TIMEOUT = 24'd10000;
  localparam logic [CFG_DATA_W-1:0] RST_SETTLE_DELAY    = 24'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_DISC_TIMEOUT    = 24'd5000;
  localparam logic [CFG_DATA_W-1:0] RST_RETRY_INTERVAL  = 24'd60000;

  // Reported state codes
  localparam logic [2:0] CODE_IDLE          = 3'd0;
  localparam logic [2:0] CODE_CONNECTING    = 3'd1;
  localparam logic [2:0] CODE_SETTLING      = 3'd2;
  localparam logic [2:0] CODE_CONNECTED     = 3'd3;
  localparam logic [2:0] CODE_DISCONNECTING = 3'd4;
  localparam logic [2:0] CODE_FALLBACK      = 3'd5;
  localparam logic [2:0] CODE_RETRY         = 3'd6;

  // Radio mode codes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_STA  = 2'd1;
  localparam logic [1:0] MODE_AP   = 2'd2;
  localparam logic [1:0] MODE_BOTH = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE          = 7'b0000001,
    ST_CONNECTING    = 7'b0000010,
    ST_SETTLING      = 7'b0000100,
    ST_CONNECTED     = 7'b0001000,
    ST_DISCONNECTING = 7'b0010000,
    ST_FALLBACK      = 7'b0100000,
    ST_RETRY         = 7'b1000000
  } lcs_state_e_t;

  typedef struct packed {
    logic enabled;
    logic link_up;
    logic new_credentials;
  } lcs_in_t;

  typedef struct packed {
    logic [2:0] fsm_state;
    logic       is_connected;
    logic       is_fallback;
    logic       cmd_station_begin;
    logic       cmd_station_drop;
    logic       cmd_ap_start;
    logic       cmd_ap_stop;
    logic [1:0] radio_mode;
    logic       notify_up;
    logic       notify_down;
    logic       notify_ap_started;
  } lcs_out_t;

  typedef struct packed {
    logic [TICK_W-1:0]     tick_period;
    logic [CFG_DATA_W-1:0] connect_timeout;
    logic [CFG_DATA_W-1:0] settle_delay;
    logic [CFG_DATA_W-1:0] disconnect_timeout;
    logic [CFG_DATA_W-1:0] fallback_retry_interval;
    logic                  fallback_enable;
  } lcs_cfg_t;

  // Supervisor state carried between ticks
  typedef struct packed {
    lcs_state_e_t          mode;
    logic [TIMER_BITS-1:0] countdown;
    logic                  restart_pending;
  } lcs_ctx_t;

  // Fit a register value to the countdown width (truncate or zero-extend)
  function automatic logic [TIMER_BITS-1:0] to_timer(input logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W+TIMER_BITS-1:0] wide;
    wide = {{TIMER_BITS{1'b0}}, v};
    return wide[TIMER_BITS-1:0];
  endfunction

  function automatic logic [2:0] state_code(input lcs_state_e_t s);
    logic [2:0] c;
    unique case (s)
      ST_CONNECTING:    c = CODE_CONNECTING;
      ST_SETTLING:      c = CODE_SETTLING;
      ST_CONNECTED:     c = CODE_CONNECTED;
      ST_DISCONNECTING: c = CODE_DISCONNECTING;
      ST_FALLBACK:      c = CODE_FALLBACK;
      ST_RETRY:         c = CODE_RETRY;
      default:          c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/lcs_fsm.sv]
// Next-state and result logic for one tick of the supervisor.
// Purely combinational; depends on lcs_pkg.
`default_nettype none

module lcs_fsm (
  input  lcs_pkg::lcs_ctx_t ctx,
  input  lcs_pkg::lcs_cfg_t cfg,
  input  lcs_pkg::lcs_in_t  tick,
  output lcs_pkg::lcs_ctx_t ctx_nxt,
  output lcs_pkg::lcs_out_t res
);
  import lcs_pkg::*;

  logic [TIMER_BITS-1:0] tick_ext;
  logic [TIMER_BITS-1:0] cd_dec;
  logic                  timeout;
  logic                  rp;
  lcs_state_e_t          st;
  logic [1:0]            mode;
  logic                  begin_c, drop, ap_start, ap_stop, n_up, n_down, n_ap;

  assign tick_ext = {{(TIMER_BITS-TICK_W){1'b0}}, cfg.tick_period};
  assign cd_dec   = (ctx.countdown > tick_ext) ? (ctx.countdown - tick_ext) : '0;
  assign timeout  = (cd_dec == '0);

  always_comb begin
    // pulse latches unless idle; a latched request acts this tick
    rp       = ctx.restart_pending | (tick.new_credentials & (ctx.mode != ST_IDLE));
    st       = ctx.mode;
    ctx_nxt.countdown = cd_dec;
    mode     = MODE_NONE;
    begin_c  = 1'b0;
    drop     = 1'b0;
    ap_start = 1'b0;
    ap_stop  = 1'b0;
    n_up     = 1'b0;
    n_down   = 1'b0;
    n_ap     = 1'b0;

    unique case (ctx.mode)
      ST_CONNECTING: begin
        if (tick.link_up) begin
          ctx_nxt.countdown = to_timer(cfg.settle_delay);
          st = ST_SETTLING;
        end else if (!tick.enabled || rp) begin
          drop = 1'b1;
          ctx_nxt.countdown = to_timer(cfg.disconnect_timeout);
          st = ST_DISCONNECTING;
        end else if (timeout) begin
          drop = 1'b1;
          if (cfg.fallback_enable) begin
            mode = MODE_AP; ap_start = 1'b1; n_ap = 1'b1;
            ctx_nxt.countdown = to_timer(cfg.fallback_retry_interval);
            st = ST_FALLBACK;
          end else begin
            ctx_nxt.countdown = to_timer(cfg.disconnect_timeout);
            st = ST_DISCONNECTING;
          end
        end
      end
      ST_SETTLING: begin
        if (!tick.enabled || !tick.link_up) begin
          drop = 1'b1;
          ctx_nxt.countdown = to_timer(cfg.disconnect_timeout);
          st = ST_DISCONNECTING;
        end else if (timeout) begin
          n_up = 1'b1;
          st = ST_CONNECTED;
        end else if (rp) begin
          drop = 1'b1;
          ctx_nxt.countdown = to_timer(cfg.disconnect_timeout);
          st = ST_DISCONNECTING;
        end
      end
      ST_CONNECTED: begin
        if (!tick.enabled || !tick.link_up || rp) begin
          if (tick.enabled && tick.link_up) rp = 1'b0;
          n_down = 1'b1; drop = 1'b1;
          ctx_nxt.countdown = to_timer(cfg.disconnect_timeout);
          st = ST_DISCONNECTING;
        end
      end
      ST_DISCONNECTING: begin
        if (!tick.link_up || timeout) st = ST_IDLE;
        rp = 1'b0;
      end
      ST_FALLBACK: begin
        if (!tick.enabled) begin
          ap_stop = 1'b1; mode = MODE_STA; n_down = 1'b1;
          st = ST_IDLE;
        end else if (timeout) begin
          mode = MODE_BOTH; begin_c = 1'b1;
          ctx_nxt.countdown = to_timer(cfg.connect_timeout);
          st = ST_RETRY;
        end else if (rp) begin
          ap_stop = 1'b1; mode = MODE_STA; n_down = 1'b1;
          rp = 1'b0;
          st = ST_IDLE;
        end
      end
      ST_RETRY: begin
        if (!tick.enabled || rp) begin
          if (tick.enabled) rp = 1'b0;
          ap_stop = 1'b1; drop = 1'b1; mode = MODE_STA; n_down = 1'b1;
          st = ST_IDLE;
        end else if (tick.link_up) begin
          ap_stop = 1'b1; mode = MODE_STA;
          ctx_nxt.countdown = to_timer(cfg.settle_delay);
          st = ST_SETTLING;
        end else if (timeout) begin
          drop = 1'b1; mode = MODE_AP;
          ctx_nxt.countdown = to_timer(cfg.fallback_retry_interval);
          st = ST_FALLBACK;
        end
      end
      default: begin  // idle, and any stray code acts as idle
        st = ST_IDLE;
        if (tick.enabled) begin
          mode = MODE_STA; begin_c = 1'b1;
          ctx_nxt.countdown = to_timer(cfg.connect_timeout);
          st = ST_CONNECTING;
        end
        rp = 1'b0;
      end
    endcase

    ctx_nxt.mode            = st;
    ctx_nxt.restart_pending = rp;

    res.fsm_state         = state_code(st);
    res.is_connected      = (st == ST_CONNECTED);
    res.is_fallback       = (st == ST_FALLBACK) || (st == ST_RETRY);
    res.cmd_station_begin = begin_c;
    res.cmd_station_drop  = drop;
    res.cmd_ap_start      = ap_start;
    res.cmd_ap_stop       = ap_stop;
    res.radio_mode        = mode;
    res.notify_up         = n_up;
    res.notify_down       = n_down;
    res.notify_ap_started = n_ap;
  end

endmodule

`default_nettype wire

[sv/link_connection_supervisor.sv]
// Link connection supervisor, top level: tick input register, config registers,
// supervisor state and result register. Depends on lcs_pkg and lcs_fsm.
// Each tick passes through the input register, then the result register.
// Throughput: one tick per clock if out_stall is low; one state update per tick.
// Reset (rst_n low, synchronous): pipeline empty, state idle, countdown 0,
// no restart pending, config registers back to their defaults.
`default_nettype none

module link_connection_supervisor (
  input  wire                              clk,
  input  wire                              rst_n,
  // tick channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  lcs_pkg::lcs_in_t                 in_data,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output lcs_pkg::lcs_out_t                out_data,
  // config write port
  input  wire                              cfg_we,
  input  wire [lcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [lcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lcs_pkg::*;

  lcs_cfg_t cfg_r;

  // stage 1: registered tick
  logic     s1_valid_r;
  lcs_in_t  s1_data_r;

  // supervisor state, updated when a tick moves into the result register
  lcs_ctx_t ctx_r;
  lcs_ctx_t ctx_nxt;
  lcs_out_t res_nxt;

  logic     out_valid_r;
  lcs_out_t out_data_r;

  logic     out_load;   // result register can take a new transaction
  logic     s1_fire;    // stage 1 transaction moves to the result register
  logic     in_fire;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // Config registers; values are masked to register width by the port
  // slicing. Indexes past the last register are dropped.
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period             <= RST_TICK_PERIOD;
      cfg_r.connect_timeout         <= RST_CONNECT_TIMEOUT;
      cfg_r.settle_delay            <= RST_SETTLE_DELAY;
      cfg_r.disconnect_timeout      <= RST_DISC_TIMEOUT;
      cfg_r.fallback_retry_interval <= RST_RETRY_INTERVAL;
      cfg_r.fallback_enable         <= 1'b0;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_TICK_PERIOD:     cfg_r.tick_period             <= cfg_data[TICK_W-1:0];
        REG_CONNECT_TIMEOUT: cfg_r.connect_timeout         <= cfg_data;
        REG_SETTLE_DELAY:    cfg_r.settle_delay            <= cfg_data;
        REG_DISC_TIMEOUT:    cfg_r.disconnect_timeout      <= cfg_data;
        REG_RETRY_INTERVAL:  cfg_r.fallback_retry_interval <= cfg_data;
        REG_FALLBACK_EN:     cfg_r.fallback_enable         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Tick input register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  // ---------------------------------------------------------------
  // One tick of the state machine: saturating countdown, then transition
  // ---------------------------------------------------------------
  lcs_fsm u_fsm (
    .ctx     (ctx_r),
    .cfg     (cfg_r),
    .tick    (s1_data_r),
    .ctx_nxt (ctx_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.mode            <= ST_IDLE;
      ctx_r.countdown       <= '0;
      ctx_r.restart_pending <= 1'b0;
    end else if (s1_fire) begin
      ctx_r <= ctx_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Result register: holds while the consumer stalls
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= res_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------

  // a transaction leaving stage 1 shows up as the result, matching the new state
  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r && (out_data_r.fsm_state == state_code(ctx_r.mode)))
    else $error("result state does not match supervisor state");

  // the input side stalls only when both registers are occupied and blocked
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // connected notification only on entry to the connected state
  a_notify_up_connected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.notify_up) |->
      (out_data_r.fsm_state == CODE_CONNECTED) && out_data_r.is_connected)
    else $error("notify_up without connected state");

  // state only changes when a tick is consumed
  a_state_moves_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(ctx_r))
    else $error("supervisor state changed without a tick");

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for link_connection_supervisor: directed and random tick transactions,
// each result checked field by field against a behavioral model of the supervisor.
// Depends on lcs_pkg and the supervisor RTL.
`timescale 1ns / 100ps

module tb;
  import lcs_pkg::*;

  // Register indexes past the last real register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // How long the receiver stops taking results when asked to hold off.
  localparam int RX_HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  lcs_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lcs_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  link_connection_supervisor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Ticks waiting to be offered, and results the model says must come back, in order.
  lcs_in_t  pending_ticks[$];
  lcs_out_t awaited_results[$];

  int mismatches = 0;
  int send_idle_pct = 10;
  int recv_stall_pct = 77;
  logic rx_hold_req = 1'b0;
  int rx_hold_left = 0;

  // Stimulus generator levels: enable and link status change slowly, like the real thing.
  logic gen_en = 1'b1;
  logic gen_up = 1'b0;

  // Model copy of the configuration registers.
  logic [TICK_W-1:0]     cfg_tick;
  logic [CFG_DATA_W-1:0] cfg_connect;
  logic [CFG_DATA_W-1:0] cfg_settle;
  logic [CFG_DATA_W-1:0] cfg_disc;
  logic [CFG_DATA_W-1:0] cfg_retry;
  logic                  cfg_fallback;

  // Model copy of the supervisor state: reported state code, countdown, restart request.
  logic [2:0]            sup_state;
  logic [TIMER_BITS-1:0] sup_count;
  logic                  sup_restart;

  // One supervisor tick: latch restart, run the countdown, take one transition.
  // Register values are narrowed or widened to the timer width on load.
  function automatic lcs_out_t supervise_tick(input lcs_in_t t);
    lcs_out_t              r;
    logic [2:0]            st;
    logic                  timed_out;
    logic [TIMER_BITS-1:0] tick_w;
    r = '0;
    st = sup_state;
    tick_w = {{(TIMER_BITS-TICK_W){1'b0}}, cfg_tick};
    // Credentials only count once we are out of idle; the request acts this same tick.
    if (t.new_credentials && st != CODE_IDLE)
      sup_restart = 1'b1;
    if (sup_count > tick_w)
      sup_count = sup_count - tick_w;
    else
      sup_count = '0;
    timed_out = (sup_count == '0);

    case (st)
      CODE_CONNECTING: begin
        if (t.link_up) begin
          sup_count = to_timer(cfg_settle);
          st = CODE_SETTLING;
        end else if (!t.enabled || sup_restart) begin
          r.cmd_station_drop = 1'b1;
          sup_count = to_timer(cfg_disc);
          st = CODE_DISCONNECTING;
        end else if (timed_out) begin
          r.cmd_station_drop = 1'b1;
          if (cfg_fallback) begin
            r.radio_mode = MODE_AP;
            r.cmd_ap_start = 1'b1;
            r.notify_ap_started = 1'b1;
            sup_count = to_timer(cfg_retry);
            st = CODE_FALLBACK;
          end else begin
            sup_count = to_timer(cfg_disc);
            st = CODE_DISCONNECTING;
          end
        end
      end
      CODE_SETTLING: begin
        // Losing the link beats the settle timer, which beats a restart.
        if (!t.enabled || !t.link_up) begin
          r.cmd_station_drop = 1'b1;
          sup_count = to_timer(cfg_disc);
          st = CODE_DISCONNECTING;
        end else if (timed_out) begin
          r.notify_up = 1'b1;
          st = CODE_CONNECTED;
        end else if (sup_restart) begin
          r.cmd_station_drop = 1'b1;
          sup_count = to_timer(cfg_disc);
          st = CODE_DISCONNECTING;
        end
      end
      CODE_CONNECTED: begin
        if (!t.enabled || !t.link_up || sup_restart) begin
          if (t.enabled && t.link_up)
            sup_restart = 1'b0;
          r.notify_down = 1'b1;
          r.cmd_station_drop = 1'b1;
          sup_count = to_timer(cfg_disc);
          st = CODE_DISCONNECTING;
        end
      end
      CODE_DISCONNECTING: begin
        if (!t.link_up || timed_out)
          st = CODE_IDLE;
        sup_restart = 1'b0;
      end
      CODE_FALLBACK: begin
        if (!t.enabled) begin
          r.cmd_ap_stop = 1'b1;
          r.radio_mode = MODE_STA;
          r.notify_down = 1'b1;
          st = CODE_IDLE;
        end else if (timed_out) begin
          r.radio_mode = MODE_BOTH;
          r.cmd_station_begin = 1'b1;
          sup_count = to_timer(cfg_connect);
          st = CODE_RETRY;
        end else if (sup_restart) begin
          r.cmd_ap_stop = 1'b1;
          r.radio_mode = MODE_STA;
          r.notify_down = 1'b1;
          sup_restart = 1'b0;
          st = CODE_IDLE;
        end
      end
      CODE_RETRY: begin
        if (!t.enabled || sup_restart) begin
          if (t.enabled)
            sup_restart = 1'b0;
          r.cmd_ap_stop = 1'b1;
          r.cmd_station_drop = 1'b1;
          r.radio_mode = MODE_STA;
          r.notify_down = 1'b1;
          st = CODE_IDLE;
        end else if (t.link_up) begin
          r.cmd_ap_stop = 1'b1;
          r.radio_mode = MODE_STA;
          sup_count = to_timer(cfg_settle);
          st = CODE_SETTLING;
        end else if (timed_out) begin
          r.cmd_station_drop = 1'b1;
          r.radio_mode = MODE_AP;
          sup_count = to_timer(cfg_retry);
          st = CODE_FALLBACK;
        end
      end
      default: begin
        // Idle, and the unused code behaves the same way.
        if (t.enabled) begin
          r.radio_mode = MODE_STA;
          r.cmd_station_begin = 1'b1;
          sup_count = to_timer(cfg_connect);
          st = CODE_CONNECTING;
        end
        sup_restart = 1'b0;
      end
    endcase

    sup_state = st;
    r.fsm_state = st;
    r.is_connected = (st == CODE_CONNECTED);
    r.is_fallback = (st == CODE_FALLBACK) || (st == CODE_RETRY);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Driver: offers queued ticks; a stalled transaction holds its payload.
  // Each accepted tick is run through the model right away.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        awaited_results.push_back(supervise_tick(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and drives the result stall, including
  // the long hold-off that backs the block up into its input.
  always @(posedge clk) begin
    lcs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited, raw", int'(out_data), 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.fsm_state !== want.fsm_state)
          report_mismatch("fsm_state", int'(out_data.fsm_state), int'(want.fsm_state));
        if (out_data.is_connected !== want.is_connected)
          report_mismatch("is_connected", int'(out_data.is_connected),
                          int'(want.is_connected));
        if (out_data.is_fallback !== want.is_fallback)
          report_mismatch("is_fallback", int'(out_data.is_fallback),
                          int'(want.is_fallback));
        if (out_data.cmd_station_begin !== want.cmd_station_begin)
          report_mismatch("cmd_station_begin", int'(out_data.cmd_station_begin),
                          int'(want.cmd_station_begin));
        if (out_data.cmd_station_drop !== want.cmd_station_drop)
          report_mismatch("cmd_station_drop", int'(out_data.cmd_station_drop),
                          int'(want.cmd_station_drop));
        if (out_data.cmd_ap_start !== want.cmd_ap_start)
          report_mismatch("cmd_ap_start", int'(out_data.cmd_ap_start),
                          int'(want.cmd_ap_start));
        if (out_data.cmd_ap_stop !== want.cmd_ap_stop)
          report_mismatch("cmd_ap_stop", int'(out_data.cmd_ap_stop),
                          int'(want.cmd_ap_stop));
        if (out_data.radio_mode !== want.radio_mode)
          report_mismatch("radio_mode", int'(out_data.radio_mode), int'(want.radio_mode));
        if (out_data.notify_up !== want.notify_up)
          report_mismatch("notify_up", int'(out_data.notify_up), int'(want.notify_up));
        if (out_data.notify_down !== want.notify_down)
          report_mismatch("notify_down", int'(out_data.notify_down),
                          int'(want.notify_down));
        if (out_data.notify_ap_started !== want.notify_ap_started)
          report_mismatch("notify_ap_started", int'(out_data.notify_ap_started),
                          int'(want.notify_ap_started));
      end
    end
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req) begin
      out_stall <= 1'b1;
      rx_hold_left <= RX_HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Config write, one register per transaction; the model copy follows with the
  // same masking. Only called while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TICK_PERIOD:     cfg_tick = val[TICK_W-1:0];
      REG_CONNECT_TIMEOUT: cfg_connect = val;
      REG_SETTLE_DELAY:    cfg_settle = val;
      REG_DISC_TIMEOUT:    cfg_disc = val;
      REG_RETRY_INTERVAL:  cfg_retry = val;
      REG_FALLBACK_EN:     cfg_fallback = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] tick, input logic [CFG_DATA_W-1:0] conn,
                            input logic [CFG_DATA_W-1:0] settle,
                            input logic [CFG_DATA_W-1:0] disc,
                            input logic [CFG_DATA_W-1:0] retry,
                            input logic [CFG_DATA_W-1:0] fb);
    write_reg(REG_TICK_PERIOD, tick);
    write_reg(REG_CONNECT_TIMEOUT, conn);
    write_reg(REG_SETTLE_DELAY, settle);
    write_reg(REG_DISC_TIMEOUT, disc);
    write_reg(REG_RETRY_INTERVAL, retry);
    write_reg(REG_FALLBACK_EN, fb);
  endtask

  // Sender pause: nothing left to offer, nothing in flight, then room for the
  // two-stage pipe to go quiet.
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly plausible sequences: enable and link level in runs, rare credential
  // pulses; the rest is random noise.
  task automatic queue_ticks(input int n);
    lcs_in_t t;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) begin
        t = lcs_in_t'(3'($urandom_range(7)));
      end else begin
        if ($urandom_range(99) < 6)
          gen_en = ~gen_en;
        if ($urandom_range(99) < 12)
          gen_up = ~gen_up;
        t.enabled = gen_en;
        t.link_up = gen_up;
        t.new_credentials = ($urandom_range(99) < 5);
      end
      pending_ticks.push_back(t);
    end
  endtask

  initial begin
    cfg_tick = RST_TICK_PERIOD;
    cfg_connect = RST_CONNECT_TIMEOUT;
    cfg_settle = RST_SETTLE_DELAY;
    cfg_disc = RST_DISC_TIMEOUT;
    cfg_retry = RST_RETRY_INTERVAL;
    cfg_fallback = 1'b0;
    sup_state = CODE_IDLE;
    sup_count = '0;
    sup_restart = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset timing. Payload bits are {enabled, link_up, new_credentials}.
    pending_ticks.push_back(lcs_in_t'(3'b001)); // credentials while idle: ignored
    pending_ticks.push_back(lcs_in_t'(3'b101)); // start join, pulse still ignored
    pending_ticks.push_back(lcs_in_t'(3'b110)); // link up -> settling
    pending_ticks.push_back(lcs_in_t'(3'b111)); // restart latched, acts same tick
    pending_ticks.push_back(lcs_in_t'(3'b110)); // disconnecting, link still up
    pending_ticks.push_back(lcs_in_t'(3'b100)); // link gone -> idle
    wait_drained();

    // Tiny timers with fallback on; spare indexes must not disturb anything.
    set_timing(24'd1, 24'd2, 24'd2, 24'd2, 24'd3, 24'd1);
    write_reg(REG_SPARE_A, 24'hFFFFFF);
    write_reg(REG_SPARE_B, 24'h000000);
    pending_ticks.push_back(lcs_in_t'(3'b100)); // idle -> connecting
    pending_ticks.push_back(lcs_in_t'(3'b100));
    pending_ticks.push_back(lcs_in_t'(3'b100)); // connect timeout -> access point
    pending_ticks.push_back(lcs_in_t'(3'b100));
    pending_ticks.push_back(lcs_in_t'(3'b100));
    pending_ticks.push_back(lcs_in_t'(3'b100)); // retry interval up -> station retry
    pending_ticks.push_back(lcs_in_t'(3'b110)); // link up during retry -> settling
    pending_ticks.push_back(lcs_in_t'(3'b110));
    pending_ticks.push_back(lcs_in_t'(3'b110)); // settled -> connected
    pending_ticks.push_back(lcs_in_t'(3'b111)); // restart while connected
    pending_ticks.push_back(lcs_in_t'(3'b010));
    pending_ticks.push_back(lcs_in_t'(3'b010)); // disconnect timer ends -> idle
    pending_ticks.push_back(lcs_in_t'(3'b100));
    pending_ticks.push_back(lcs_in_t'(3'b100));
    pending_ticks.push_back(lcs_in_t'(3'b100)); // back in access point mode
    pending_ticks.push_back(lcs_in_t'(3'b101)); // restart from access point -> idle
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_timing(CFG_DATA_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom_range(0, 20)),
                      CFG_DATA_W'($urandom_range(0, 20)), CFG_DATA_W'($urandom_range(0, 20)),
                      CFG_DATA_W'($urandom_range(0, 20)), 24'd1);
        // All ones; the tick and enable registers keep only their low bits.
        1: set_timing(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        // Everything times out at once; upper bits alone must leave tick and enable at 0.
        2: set_timing(24'h010000, 24'd0, 24'd0, 24'd0, 24'd0, 24'hFFFFFE);
        // Zero tick: the countdown never moves, so timers loaded in this phase never run out.
        3: set_timing(24'd0, CFG_DATA_W'($urandom_range(1, 30)),
                      CFG_DATA_W'($urandom_range(1, 30)), CFG_DATA_W'($urandom_range(1, 30)),
                      CFG_DATA_W'($urandom_range(1, 30)), 24'd1);
        4: set_timing(CFG_DATA_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom_range(0, 20)),
                      CFG_DATA_W'($urandom_range(0, 20)), CFG_DATA_W'($urandom_range(0, 20)),
                      CFG_DATA_W'($urandom_range(0, 20)), CFG_DATA_W'($urandom_range(0, 1)));
        default: set_timing(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      endcase
      send_idle_pct <= (p < 2) ? 10 : (p < 4) ? 77 : 0;
      recv_stall_pct <= (p < 2) ? 77 : (p < 4) ? 10 : 0;
      if (p == 4) begin
        queue_ticks(57);
        wait_drained();
        // Receiver goes dark while the sender keeps pushing.
        rx_hold_req <= 1'b1;
        @(posedge clk);
        rx_hold_req <= 1'b0;
        queue_ticks(58);
      end else begin
        queue_ticks(115);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
